>>> src/lfu_record_cache_defines.svh
// ----------------------------------------------------------------------------
// lfu record cache assertion macros
// shared assertion helpers for the cache rtl, clocked on i_clk
// ----------------------------------------------------------------------------
`ifndef LFU_RECORD_CACHE_DEFINES_SVH
`define LFU_RECORD_CACHE_DEFINES_SVH

// checked only outside reset
`define LRC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define LRC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

>>> src/lrc_pkg.sv
// ----------------------------------------------------------------------------
// lrc_pkg
// types and constants shared by the lfu record cache modules
// ----------------------------------------------------------------------------
package lrc_pkg;

    localparam int DEF_ENTRIES = 8;
    localparam int REQ_W       = 2;
    localparam int KEY_W       = 16;
    localparam int WORD_W      = 32;
    localparam int PAY_W       = 4 * WORD_W;
    localparam int COUNT_W     = 16;
    localparam int SLOT_W      = 3;
    localparam int USED_W      = 4;
    localparam int IN_TDATA_W  = 144;
    localparam int OUT_TDATA_W = 168;
    localparam int OUT_TUSER_W = 2;

    typedef enum logic [REQ_W-1:0] {
        REQ_UPDATE = 2'd0,
        REQ_LOOKUP = 2'd1,
        REQ_CLEAR  = 2'd2
    } t_req;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_BUMP,
        S_SCAN,
        S_EVICT
    } t_state;

    typedef struct packed {
        logic cap;
        logic look;
        logic fill;
        logic miss_resp;
        logic clear;
        logic bump;
        logic scan_start;
        logic scan;
        logic evict;
    } t_dp_cmd;

    typedef struct packed {
        logic [REQ_W-1:0] req;
        logic             hit;
        logic             full;
        logic             scan_done;
        logic             out_free;
    } t_dp_sts;

endpackage

>>> src/lrc_ctrl.sv
// ----------------------------------------------------------------------------
// lrc_ctrl
// request sequencer: tag lookup, count update, victim scan and response load
// ----------------------------------------------------------------------------
module lrc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  lrc_pkg::t_dp_sts i_sts,
    output lrc_pkg::t_dp_cmd o_cmd
);
    import lrc_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   upd_miss;

    assign upd_miss = (i_sts.req == REQ_UPDATE) && !i_sts.hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                priority if (((i_sts.req == REQ_UPDATE) || (i_sts.req == REQ_LOOKUP))
                              && i_sts.hit) begin
                    n_state = S_BUMP;
                end else if (upd_miss && i_sts.full) begin
                    n_state = S_SCAN;
                end else if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_LOOK;
                end
            end
            S_BUMP: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_SCAN: begin
                if (i_sts.scan_done) begin
                    n_state = S_EVICT;
                end
            end
            S_EVICT: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd         = '0;
        s_axis_tready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                s_axis_tready = 1'b1;
                o_cmd.cap     = s_axis_tvalid;
            end
            S_LOOK: begin
                o_cmd.look       = 1'b1;
                o_cmd.fill       = upd_miss && !i_sts.full && i_sts.out_free;
                o_cmd.scan_start = upd_miss && i_sts.full;
                o_cmd.clear      = (i_sts.req == REQ_CLEAR) && i_sts.out_free;
                o_cmd.miss_resp  = i_sts.out_free &&
                                   (((i_sts.req == REQ_LOOKUP) && !i_sts.hit) ||
                                    ((i_sts.req != REQ_UPDATE) && (i_sts.req != REQ_LOOKUP) &&
                                     (i_sts.req != REQ_CLEAR)));
            end
            S_BUMP: begin
                o_cmd.bump = i_sts.out_free;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
            end
            S_EVICT: begin
                o_cmd.evict = i_sts.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

>>> src/lrc_dp.sv
// ----------------------------------------------------------------------------
// lrc_dp
// tag registers, count and payload memories, victim scan and response register
// ----------------------------------------------------------------------------
`include "lfu_record_cache_defines.svh"

module lrc_dp #(
    parameter int CACHE_ENTRIES = lrc_pkg::DEF_ENTRIES
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  lrc_pkg::t_dp_cmd                i_cmd,
    output lrc_pkg::t_dp_sts                o_sts,
    input  logic [lrc_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic [lrc_pkg::REQ_W-1:0]       s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [lrc_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output logic [lrc_pkg::OUT_TUSER_W-1:0] m_axis_tuser
);
    import lrc_pkg::*;

    localparam int IDX_W = $clog2(CACHE_ENTRIES);
    localparam int TOT_W = $clog2(CACHE_ENTRIES + 1);

    // request capture
    logic [REQ_W-1:0] r_req;
    logic [KEY_W-1:0] r_key;
    logic [PAY_W-1:0] r_pay;

    // tags and valid bits
    logic [KEY_W-1:0]         r_keys [CACHE_ENTRIES];
    logic [CACHE_ENTRIES-1:0] r_valid;
    logic [TOT_W-1:0]         r_total;
    logic [TOT_W-1:0]         n_total;

    // memories
    logic [COUNT_W-1:0] cnt_mem [CACHE_ENTRIES];
    logic [PAY_W-1:0]   pay_mem [CACHE_ENTRIES];
    logic [COUNT_W-1:0] r_cnt_rd;
    logic [PAY_W-1:0]   r_pay_rd;
    logic               cnt_re;
    logic [IDX_W-1:0]   cnt_raddr;
    logic               cnt_we;
    logic [IDX_W-1:0]   cnt_waddr;
    logic [COUNT_W-1:0] cnt_wdata;
    logic               pay_we;
    logic [IDX_W-1:0]   pay_waddr;

    // match and free search
    logic             hit;
    logic [IDX_W-1:0] hit_idx;
    logic [IDX_W-1:0] free_idx;
    logic [IDX_W-1:0] r_idx;
    logic [COUNT_W-1:0] bumped;

    // victim scan
    logic               r_issue;
    logic [IDX_W-1:0]   r_scan_idx;
    logic               r_cmp_vld;
    logic [IDX_W-1:0]   r_cmp_idx;
    logic [COUNT_W-1:0] r_min;
    logic [IDX_W-1:0]   r_min_idx;

    // response register
    logic               r_o_valid;
    logic               r_o_hit;
    logic               r_o_repl;
    logic [SLOT_W-1:0]  r_o_slot;
    logic [PAY_W-1:0]   r_o_pay;
    logic [COUNT_W-1:0] r_o_cnt;
    logic [KEY_W-1:0]   r_o_ev;
    logic [USED_W-1:0]  r_o_used;
    logic               out_free;
    logic               load;
    logic [IDX_W-1:0]   res_idx;
    logic [IDX_W+SLOT_W-1:0] slot_ext;
    logic [TOT_W+USED_W-1:0] used_ext;

    always_comb begin
        hit      = 1'b0;
        hit_idx  = '0;
        free_idx = '0;
        for (int i = CACHE_ENTRIES - 1; i >= 0; i--) begin
            if (r_valid[i] && (r_keys[i] == r_key)) begin
                hit     = 1'b1;
                hit_idx = IDX_W'(i);
            end
            if (!r_valid[i]) begin
                free_idx = IDX_W'(i);
            end
        end
    end

    assign out_free = !r_o_valid || m_axis_tready;
    assign bumped   = (&r_cnt_rd) ? r_cnt_rd : r_cnt_rd + COUNT_W'(1);

    assign o_sts.req       = r_req;
    assign o_sts.hit       = hit;
    assign o_sts.full      = &r_valid;
    assign o_sts.scan_done = !r_issue && !r_cmp_vld;
    assign o_sts.out_free  = out_free;

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_req <= s_axis_tuser;
            r_key <= s_axis_tdata[KEY_W-1:0];
            r_pay <= s_axis_tdata[KEY_W +: PAY_W];
        end
        if (i_cmd.look) begin
            r_idx <= hit_idx;
        end
    end

    // count memory, one read and one write port
    assign cnt_re    = i_cmd.look || (i_cmd.scan && r_issue);
    assign cnt_raddr = i_cmd.scan ? r_scan_idx : hit_idx;
    assign cnt_we    = i_cmd.bump || i_cmd.fill || i_cmd.evict;
    assign cnt_waddr = i_cmd.bump ? r_idx : (i_cmd.fill ? free_idx : r_min_idx);
    assign cnt_wdata = i_cmd.bump ? bumped : COUNT_W'(1);

    always_ff @(posedge i_clk) begin
        if (cnt_we) begin
            cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        if (cnt_re) begin
            r_cnt_rd <= cnt_mem[cnt_raddr];
        end
    end

    // payload memory
    assign pay_we    = (i_cmd.bump && (r_req == REQ_UPDATE)) || i_cmd.fill || i_cmd.evict;
    assign pay_waddr = cnt_waddr;

    always_ff @(posedge i_clk) begin
        if (pay_we) begin
            pay_mem[pay_waddr] <= r_pay;
        end
        if (i_cmd.look) begin
            r_pay_rd <= pay_mem[hit_idx];
        end
    end

    // tags
    always_ff @(posedge i_clk) begin
        if (i_cmd.fill) begin
            r_keys[free_idx] <= r_key;
        end else if (i_cmd.evict) begin
            r_keys[r_min_idx] <= r_key;
        end
    end

    always_comb begin
        n_total = r_total;
        if (i_cmd.clear) begin
            n_total = '0;
        end else if (i_cmd.fill) begin
            n_total = r_total + TOT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_total <= '0;
        end else begin
            r_total <= n_total;
            if (i_cmd.clear) begin
                r_valid <= '0;
            end else if (i_cmd.fill) begin
                r_valid[free_idx] <= 1'b1;
            end
        end
    end

    // victim scan, one count read per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issue   <= 1'b0;
            r_cmp_vld <= 1'b0;
        end else if (i_cmd.scan_start) begin
            r_issue    <= 1'b1;
            r_cmp_vld  <= 1'b0;
            r_scan_idx <= '0;
        end else if (i_cmd.scan) begin
            r_cmp_vld <= r_issue;
            r_cmp_idx <= r_scan_idx;
            if (r_issue) begin
                if (r_scan_idx == IDX_W'(CACHE_ENTRIES - 1)) begin
                    r_issue <= 1'b0;
                end else begin
                    r_scan_idx <= r_scan_idx + IDX_W'(1);
                end
            end
            if (r_cmp_vld && ((r_cmp_idx == '0) || (r_cnt_rd < r_min))) begin
                r_min     <= r_cnt_rd;
                r_min_idx <= r_cmp_idx;
            end
        end
    end

    // response register
    assign load     = i_cmd.fill || i_cmd.miss_resp || i_cmd.clear || i_cmd.bump || i_cmd.evict;
    assign res_idx  = i_cmd.bump ? r_idx : (i_cmd.fill ? free_idx : r_min_idx);
    assign slot_ext = {SLOT_W'(0), res_idx};
    assign used_ext = {USED_W'(0), n_total};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (load) begin
            r_o_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_o_used <= used_ext[USED_W-1:0];
            r_o_hit  <= i_cmd.bump;
            r_o_repl <= i_cmd.evict;
            r_o_ev   <= i_cmd.evict ? r_keys[r_min_idx] : '0;
            if (i_cmd.bump || i_cmd.fill || i_cmd.evict) begin
                r_o_slot <= slot_ext[SLOT_W-1:0];
                r_o_cnt  <= i_cmd.bump ? bumped : COUNT_W'(1);
            end else begin
                r_o_slot <= '0;
                r_o_cnt  <= '0;
            end
            r_o_pay <= (i_cmd.bump && (r_req == REQ_LOOKUP)) ? r_pay_rd : '0;
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tuser  = {r_o_repl, r_o_hit};
    assign m_axis_tdata  = {1'b0, r_o_used, r_o_ev, r_o_cnt, r_o_pay, r_o_slot};

    `LRC_ASSERT(a_total_matches_valid, $countones(r_valid) == int'(r_total), "fill count off")
    `LRC_ASSERT(a_fill_has_room, i_cmd.fill |-> !(&r_valid), "fill with no free entry")
    `LRC_ASSERT(a_evict_only_full, (r_o_valid && r_o_repl) |-> (&r_valid), "evict while not full")
    `LRC_ASSERT_ALWAYS(a_reset_empties, !i_rst_n |=> (r_total == '0) && !r_o_valid,
        "reset left state")

endmodule

>>> src/lfu_record_cache.sv
// ----------------------------------------------------------------------------
// lfu_record_cache
// fully associative record cache with least-frequently-used replacement
// ----------------------------------------------------------------------------
// channel   dir  tdata                                          tuser
// s_axis    in   zone_id, temperature, smoke, humidity, risk    req_type
// m_axis    out  slot, payload words, use_count, evicted, used  hit, replaced
//
// miss fill, lookup miss, clear: accept, then tag compare with the response load
// hit on update or lookup: accept, tag compare and count memory read, then count bump
// eviction: accept, tag compare, victim scan, then evict; the scan reads one count per cycle
// reset empties the cache at once; no clearing pass
// a stalled m_axis holds the request in its final step until the transfer
// ----------------------------------------------------------------------------
module lfu_record_cache #(
    parameter int CACHE_ENTRIES = lrc_pkg::DEF_ENTRIES
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // zone_id, temperature_bits, smoke_bits, humidity_bits, risk_bits
    input  logic [lrc_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // req_type
    input  logic [lrc_pkg::REQ_W-1:0]       s_axis_tuser,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // slot, out_temperature, out_smoke, out_humidity, out_risk, use_count,
    // evicted_zone, used_slots, zero pad
    output logic [lrc_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // hit, replaced
    output logic [lrc_pkg::OUT_TUSER_W-1:0] m_axis_tuser
);
    import lrc_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    lrc_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .i_sts         (sts),
        .o_cmd         (cmd)
    );

    lrc_dp #(
        .CACHE_ENTRIES (CACHE_ENTRIES)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule
